/* rtl/core/ssr_pkg.sv */
// shared types and constants for the set-point soft start ramp
package ssr_pkg;

   localparam int MAX_RAMP_MS_DEF = 10000;
   localparam int RAMP_MAX_W      = 16;

   localparam int ID_W     = 8;
   localparam int TYPE_W   = 2;
   localparam int VALUE_W  = 32;
   localparam int TIME_W   = 32;
   localparam int DUR_W    = 14;
   localparam int PERIOD_W = 10;

   localparam int MAG_W  = VALUE_W + 1;
   localparam int PROD_W = MAG_W + DUR_W;
   localparam int CNT_W  = $clog2(PROD_W);

   localparam int REQ_DATA_W = ID_W + VALUE_W;
   localparam int REQ_USER_W = 1 + TYPE_W;
   localparam int RSP_DATA_W = ID_W + VALUE_W;
   localparam int RSP_USER_W = TYPE_W;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = DUR_W;

   localparam logic [DUR_W-1:0]    DURATION_RESET = DUR_W'(500);
   localparam logic [PERIOD_W-1:0] PERIOD_RESET   = PERIOD_W'(20);

   localparam logic KIND_SETPOINT = 1'b0;
   localparam logic KIND_TICK     = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] REG_ENABLE   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_DURATION = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_PERIOD   = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_APPLY,
      ST_SEND
   } state_type;

endpackage

/* rtl/core/setpoint_soft_start_ramp_top.sv */
// set-point soft start ramp: tick counter, linear ramp through one shared divider
//
// channel  dir  handshake            payload
// req      in   req_tvalid/tready    tdata: ctrl_id, target_value; tuser: kind, setpoint_type
// rsp      out  rsp_tvalid/tready    tdata: command_id, command_value; tuser: command_type
// csr      in   csr_valid/ready      csr_index, csr_data
//
// a set-point item or a tick before the first one is taken in idle and leaves the block idle;
// any other tick without a ramp step goes through the send state
// a tick during a ramp goes through multiply, divide, apply and send: one multiply, then one
// restoring divide step per cycle through a single subtract and compare
// reset is synchronous; registers come back to enabled, 500 ms ramp, 20 ms period
// a waiting result holds in the output register; a tick that sends stalls until it is free
module setpoint_soft_start_ramp_top #(
   parameter int MAX_RAMP_MS = ssr_pkg::MAX_RAMP_MS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [ssr_pkg::REQ_DATA_W-1:0]      req_tdata,   // ctrl_id, target_value
   input  logic [ssr_pkg::REQ_USER_W-1:0]      req_tuser,   // kind, setpoint_type
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [ssr_pkg::RSP_DATA_W-1:0]      rsp_tdata,   // command_id, command_value
   output logic [ssr_pkg::RSP_USER_W-1:0]      rsp_tuser,   // command_type
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ssr_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [ssr_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int DUR_W    = ssr_pkg::DUR_W;
   localparam int MAG_W    = ssr_pkg::MAG_W;
   localparam int PROD_W   = ssr_pkg::PROD_W;
   localparam int CNT_W    = ssr_pkg::CNT_W;
   localparam int VALUE_W  = ssr_pkg::VALUE_W;
   localparam int TIME_W   = ssr_pkg::TIME_W;
   localparam logic [ssr_pkg::RAMP_MAX_W-1:0] RAMP_MAX = ssr_pkg::RAMP_MAX_W'(MAX_RAMP_MS);

   ssr_pkg::state_type state_ff, state_in;

   logic [TIME_W-1:0]              now_ff, now_in;
   logic signed [VALUE_W-1:0]      applied_ff, applied_in;
   logic signed [VALUE_W-1:0]      goal_ff, goal_in;
   logic signed [VALUE_W-1:0]      start_ff, start_in;
   logic [TIME_W-1:0]              ramp_start_ff, ramp_start_in;
   logic                           ramp_active_ff, ramp_active_in;
   logic                           has_goal_ff, has_goal_in;
   logic [ssr_pkg::TYPE_W-1:0]     active_type_ff, active_type_in;
   logic [ssr_pkg::ID_W-1:0]       active_id_ff, active_id_in;
   logic [TIME_W-1:0]              last_send_ff, last_send_in;
   logic                           enabled_ff, enabled_in;
   logic [DUR_W-1:0]               duration_ff, duration_in;
   logic [ssr_pkg::PERIOD_W-1:0]   period_ff, period_in;

   logic                           diff_neg_ff, diff_neg_in;
   logic [MAG_W-1:0]               diff_mag_ff, diff_mag_in;
   logic [DUR_W-1:0]               elapsed_ff, elapsed_in;
   logic [PROD_W-1:0]              prod_ff, prod_in;
   logic [DUR_W-1:0]               rem_ff, rem_in;
   logic [CNT_W-1:0]               cnt_ff, cnt_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [ssr_pkg::TYPE_W-1:0]     rsp_type_ff, rsp_type_in;
   logic [ssr_pkg::ID_W-1:0]       rsp_id_ff, rsp_id_in;
   logic [VALUE_W-1:0]             rsp_value_ff, rsp_value_in;

   logic                           req_accept;
   logic                           req_kind;
   logic [ssr_pkg::TYPE_W-1:0]     req_type;
   logic [ssr_pkg::ID_W-1:0]       req_id;
   logic signed [VALUE_W-1:0]      req_target;

   logic [TIME_W-1:0]              now_plus;
   logic [TIME_W-1:0]              elapsed_full;
   logic                           ramp_done;
   logic signed [MAG_W-1:0]        diff;
   logic [DUR_W-1:0]               dur_clamped;
   logic [DUR_W:0]                 rem_shift;
   logic [DUR_W:0]                 rem_sub;
   logic                           rem_ge;
   logic [MAG_W-1:0]               quot;
   logic [MAG_W-1:0]               step_signed;
   logic [MAG_W-1:0]               sum;
   logic                           send_due;
   logic                           out_free;

   assign req_tready = (state_ff == ssr_pkg::ST_IDLE);
   assign csr_ready  = 1'b1;
   assign req_accept = req_tvalid && req_tready;

   assign req_kind   = req_tuser[0];
   assign req_type   = req_tuser[ssr_pkg::REQ_USER_W-1:1];
   assign req_id     = req_tdata[ssr_pkg::ID_W-1:0];
   assign req_target = $signed(req_tdata[ssr_pkg::REQ_DATA_W-1:ssr_pkg::ID_W]);

   assign now_plus     = now_ff + TIME_W'(1);
   assign elapsed_full = now_plus - ramp_start_ff;
   assign ramp_done    = elapsed_full >= TIME_W'(duration_ff);
   assign diff         = {goal_ff[VALUE_W-1], goal_ff} - {start_ff[VALUE_W-1], start_ff};

   assign rem_shift = {rem_ff, prod_ff[PROD_W-1]};
   assign rem_ge    = rem_shift >= {1'b0, duration_ff};
   assign rem_sub   = rem_shift - {1'b0, duration_ff};

   assign quot        = prod_ff[MAG_W-1:0];
   assign step_signed = diff_neg_ff ? (~quot + MAG_W'(1)) : quot;
   assign sum         = {start_ff[VALUE_W-1], start_ff} + step_signed;

   assign send_due = (now_ff - last_send_ff) >= TIME_W'(period_ff);
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      dur_clamped = csr_data[DUR_W-1:0];
      if (dur_clamped == '0) begin
         dur_clamped = DUR_W'(1);
      end
      if (ssr_pkg::RAMP_MAX_W'(dur_clamped) > RAMP_MAX) begin
         dur_clamped = RAMP_MAX[DUR_W-1:0];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ssr_pkg::ST_IDLE: begin
            if (req_accept && req_kind == ssr_pkg::KIND_TICK && has_goal_ff) begin
               if (ramp_active_ff && !ramp_done) begin
                  state_in = ssr_pkg::ST_MUL;
               end else begin
                  state_in = ssr_pkg::ST_SEND;
               end
            end
         end
         ssr_pkg::ST_MUL: state_in = ssr_pkg::ST_DIV;
         ssr_pkg::ST_DIV: begin
            if (cnt_ff == CNT_W'(PROD_W - 1)) begin
               state_in = ssr_pkg::ST_APPLY;
            end
         end
         ssr_pkg::ST_APPLY: state_in = ssr_pkg::ST_SEND;
         ssr_pkg::ST_SEND: begin
            if (!send_due || out_free) begin
               state_in = ssr_pkg::ST_IDLE;
            end
         end
         default: state_in = ssr_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      now_in         = now_ff;
      applied_in     = applied_ff;
      goal_in        = goal_ff;
      start_in       = start_ff;
      ramp_start_in  = ramp_start_ff;
      ramp_active_in = ramp_active_ff;
      has_goal_in    = has_goal_ff;
      active_type_in = active_type_ff;
      active_id_in   = active_id_ff;
      last_send_in   = last_send_ff;
      enabled_in     = enabled_ff;
      duration_in    = duration_ff;
      period_in      = period_ff;
      diff_neg_in    = diff_neg_ff;
      diff_mag_in    = diff_mag_ff;
      elapsed_in     = elapsed_ff;
      prod_in        = prod_ff;
      rem_in         = rem_ff;
      cnt_in         = cnt_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_type_in    = rsp_type_ff;
      rsp_id_in      = rsp_id_ff;
      rsp_value_in   = rsp_value_ff;

      if (csr_valid) begin
         unique case (csr_index)
            ssr_pkg::REG_ENABLE: begin
               enabled_in = csr_data[0];
               if (!csr_data[0]) begin
                  applied_in     = goal_ff;
                  ramp_active_in = 1'b0;
               end
            end
            ssr_pkg::REG_DURATION: duration_in = dur_clamped;
            ssr_pkg::REG_PERIOD:   period_in   = csr_data[ssr_pkg::PERIOD_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ssr_pkg::ST_IDLE: begin
            if (req_accept) begin
               if (req_kind == ssr_pkg::KIND_SETPOINT) begin
                  active_id_in = req_id;
                  if (!enabled_ff || (has_goal_ff && req_type != active_type_ff)) begin
                     applied_in     = req_target;
                     goal_in        = req_target;
                     start_in       = req_target;
                     ramp_active_in = 1'b0;
                  end else begin
                     start_in       = applied_ff;
                     goal_in        = req_target;
                     ramp_start_in  = now_ff;
                     ramp_active_in = 1'b1;
                  end
                  active_type_in = req_type;
                  has_goal_in    = 1'b1;
               end else begin
                  now_in      = now_plus;
                  diff_neg_in = diff[MAG_W-1];
                  diff_mag_in = diff[MAG_W-1] ? (~diff + MAG_W'(1)) : diff;
                  elapsed_in  = elapsed_full[DUR_W-1:0];
                  if (has_goal_ff && ramp_active_ff && ramp_done) begin
                     applied_in     = goal_ff;
                     ramp_active_in = 1'b0;
                  end
               end
            end
         end
         ssr_pkg::ST_MUL: begin
            prod_in = PROD_W'(diff_mag_ff) * PROD_W'(elapsed_ff);
            rem_in  = '0;
            cnt_in  = '0;
         end
         ssr_pkg::ST_DIV: begin
            rem_in  = rem_ge ? rem_sub[DUR_W-1:0] : rem_shift[DUR_W-1:0];
            prod_in = {prod_ff[PROD_W-2:0], rem_ge};
            cnt_in  = cnt_ff + CNT_W'(1);
         end
         ssr_pkg::ST_APPLY: applied_in = sum[VALUE_W-1:0];
         ssr_pkg::ST_SEND: begin
            if (send_due && out_free) begin
               last_send_in = now_ff;
               rsp_valid_in = 1'b1;
               rsp_type_in  = active_type_ff;
               rsp_id_in    = active_id_ff;
               rsp_value_in = applied_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ssr_pkg::ST_IDLE;
         now_ff         <= '0;
         applied_ff     <= '0;
         goal_ff        <= '0;
         start_ff       <= '0;
         ramp_start_ff  <= '0;
         ramp_active_ff <= 1'b0;
         has_goal_ff    <= 1'b0;
         active_type_ff <= '0;
         active_id_ff   <= '0;
         last_send_ff   <= '0;
         enabled_ff     <= 1'b1;
         duration_ff    <= ssr_pkg::DURATION_RESET;
         period_ff      <= ssr_pkg::PERIOD_RESET;
         cnt_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         now_ff         <= now_in;
         applied_ff     <= applied_in;
         goal_ff        <= goal_in;
         start_ff       <= start_in;
         ramp_start_ff  <= ramp_start_in;
         ramp_active_ff <= ramp_active_in;
         has_goal_ff    <= has_goal_in;
         active_type_ff <= active_type_in;
         active_id_ff   <= active_id_in;
         last_send_ff   <= last_send_in;
         enabled_ff     <= enabled_in;
         duration_ff    <= duration_in;
         period_ff      <= period_in;
         cnt_ff         <= cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      diff_neg_ff  <= diff_neg_in;
      diff_mag_ff  <= diff_mag_in;
      elapsed_ff   <= elapsed_in;
      prod_ff      <= prod_in;
      rem_ff       <= rem_in;
      rsp_type_ff  <= rsp_type_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_value_ff, rsp_id_ff};
   assign rsp_tuser  = rsp_type_ff;

endmodule

/* rtl/core/ssr_checker.sv */
// port-level checks for the set-point soft start ramp, bound to the top level
module ssr_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [ssr_pkg::REQ_USER_W-1:0]  req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [ssr_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic [ssr_pkg::RSP_USER_W-1:0]  rsp_tuser
);

   // a result never appears the cycle right after an item is taken
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !$rose(rsp_tvalid))
      else $error("result raised directly after an accepted item");

   // a new result is loaded only while the input side is busy
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result raised while input was ready");

   // a set-point item never leaves the block busy
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser[0] == ssr_pkg::KIND_SETPOINT |=> req_tready)
      else $error("ready dropped after a set-point item");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

endmodule

bind setpoint_soft_start_ramp_top ssr_checker u_ssr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

/* tb/tb_setpoint_soft_start_ramp_top.sv */
`timescale 1ns / 100ps
// self-checking testbench for the set-point soft start ramp with a ramp scoreboard
module tb_setpoint_soft_start_ramp_top;

   localparam int ID_W        = ssr_pkg::ID_W;
   localparam int TYPE_W      = ssr_pkg::TYPE_W;
   localparam int VALUE_W     = ssr_pkg::VALUE_W;
   localparam int PERIOD_W    = ssr_pkg::PERIOD_W;
   localparam int CSR_INDEX_W = ssr_pkg::CSR_INDEX_W;
   localparam int CSR_DATA_W  = ssr_pkg::CSR_DATA_W;
   localparam int REQ_DATA_W  = ssr_pkg::REQ_DATA_W;
   localparam int REQ_USER_W  = ssr_pkg::REQ_USER_W;
   localparam int RSP_DATA_W  = ssr_pkg::RSP_DATA_W;
   localparam int RSP_USER_W  = ssr_pkg::RSP_USER_W;

   localparam logic [TYPE_W-1:0] TYPE_RPM     = 2'd0;
   localparam logic [TYPE_W-1:0] TYPE_CURRENT = 2'd1;
   localparam logic [TYPE_W-1:0] TYPE_DUTY    = 2'd2;
   localparam logic [TYPE_W-1:0] TYPE_BRAKE   = 2'd3;
   localparam int SETTLE_CYCLES = 60;
   localparam int ITEM_TARGET   = 1550;

   typedef struct packed {
      logic                      kind;
      logic [ID_W-1:0]           ctrl_id;
      logic [TYPE_W-1:0]         setpoint_type;
      logic signed [VALUE_W-1:0] target_value;
   } req_item_type;

   typedef struct packed {
      logic [TYPE_W-1:0]         command_type;
      logic [ID_W-1:0]           command_id;
      logic signed [VALUE_W-1:0] command_value;
   } rsp_item_type;

   class ramp_scoreboard_type;
      bit                enabled;
      int unsigned       duration_ms;
      int unsigned       period_ms;
      int unsigned       now_ms;
      int unsigned       ramp_start_ms;
      int unsigned       last_send_ms;
      int                applied_value;
      int                goal_value;
      int                start_value;
      bit                ramp_active;
      bit                has_goal;
      logic [TYPE_W-1:0] active_type;
      logic [ID_W-1:0]   active_id;
      rsp_item_type      pending_cmds[$];
      int                errors;

      function new();
         enabled       = 1'b1;
         duration_ms   = 500;
         period_ms     = 20;
         now_ms        = 0;
         ramp_start_ms = 0;
         last_send_ms  = 0;
         applied_value = 0;
         goal_value    = 0;
         start_value   = 0;
         ramp_active   = 1'b0;
         has_goal      = 1'b0;
         active_type   = TYPE_RPM;
         active_id     = '0;
         errors        = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         int unsigned d;
         case (index)
            ssr_pkg::REG_ENABLE: begin
               enabled = data[0];
               if (!enabled) begin
                  applied_value = goal_value;
                  ramp_active   = 1'b0;
               end
            end
            ssr_pkg::REG_DURATION: begin
               d = 32'(data);
               if (d == 0) d = 1;
               if (d > ssr_pkg::MAX_RAMP_MS_DEF) d = ssr_pkg::MAX_RAMP_MS_DEF;
               duration_ms = d;
            end
            ssr_pkg::REG_PERIOD: period_ms = 32'(data[PERIOD_W-1:0]);
            default: ;
         endcase
      endfunction

      function void note_item(req_item_type it);
         int unsigned  elapsed;
         longint       ramp_step;
         rsp_item_type cmd;
         if (it.kind == ssr_pkg::KIND_SETPOINT) begin
            active_id = it.ctrl_id;
            if (!enabled || (has_goal && it.setpoint_type != active_type)) begin
               applied_value = it.target_value;
               goal_value    = it.target_value;
               start_value   = it.target_value;
               ramp_active   = 1'b0;
            end else begin
               start_value   = applied_value;
               goal_value    = it.target_value;
               ramp_start_ms = now_ms;
               ramp_active   = 1'b1;
            end
            active_type = it.setpoint_type;
            has_goal    = 1'b1;
            return;
         end
         now_ms++;
         if (!has_goal) return;
         if (ramp_active) begin
            elapsed = now_ms - ramp_start_ms;
            if (elapsed >= duration_ms) begin
               applied_value = goal_value;
               ramp_active   = 1'b0;
            end else begin
               // 33-bit difference, quotient truncated toward zero
               ramp_step = (longint'(goal_value) - longint'(start_value)) * longint'(elapsed)
                           / longint'(duration_ms);
               applied_value = int'(longint'(start_value) + ramp_step);
            end
         end
         if (now_ms - last_send_ms >= period_ms) begin
            last_send_ms      = now_ms;
            cmd.command_type  = active_type;
            cmd.command_id    = active_id;
            cmd.command_value = applied_value;
            pending_cmds.push_back(cmd);
         end
      endfunction

      function void check_result(rsp_item_type got);
         rsp_item_type want;
         if (pending_cmds.size() == 0) begin
            $error("unexpected item: command_type %0d command_id %0d command_value %0d",
                   got.command_type, got.command_id, got.command_value);
            errors++;
            return;
         end
         want = pending_cmds.pop_front();
         if (got.command_type !== want.command_type) begin
            $error("command_type expected %0d got %0d", want.command_type, got.command_type);
            errors++;
         end
         if (got.command_id !== want.command_id) begin
            $error("command_id expected %0d got %0d", want.command_id, got.command_id);
            errors++;
         end
         if (got.command_value !== want.command_value) begin
            $error("command_value expected %0d got %0d", want.command_value, got.command_value);
            errors++;
         end
      endfunction
   endclass

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;
   logic [REQ_USER_W-1:0]  req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic [RSP_USER_W-1:0]  rsp_tuser;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_data   = '0;

   logic [31:0]            ready_pattern = '1;
   logic [4:0]             ready_phase   = '0;

   ramp_scoreboard_type ramp_sb = new();
   int unsigned         burst_left   = 0;
   bit                  steady_phase = 1'b0;
   int                  items_sent   = 0;

   setpoint_soft_start_ramp_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      ready_phase <= ready_phase + 1'b1;
      rsp_tready  <= ready_pattern[ready_phase];
      if (ready_phase == 5'd31) begin
         case ($urandom_range(0, 3))
            0: ready_pattern <= '1;
            1: ready_pattern <= $urandom;
            2: ready_pattern <= $urandom | $urandom;
            default: ready_pattern <= $urandom & $urandom & $urandom;
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         ramp_sb.check_result(rsp_item_type'({rsp_tuser, rsp_tdata[ID_W-1:0],
                                              rsp_tdata[ID_W +: VALUE_W]}));
      end
   end

   function automatic req_item_type random_item(int unsigned command_pct);
      req_item_type it;
      it.kind          = ssr_pkg::KIND_TICK;
      it.ctrl_id       = ID_W'($urandom);
      it.setpoint_type = TYPE_W'($urandom);
      it.target_value  = $urandom;
      if ($urandom_range(1, 100) <= command_pct) begin
         it.kind = ssr_pkg::KIND_SETPOINT;
         // mostly keep the type so the command ramps
         if ($urandom_range(0, 3) != 0) it.setpoint_type = ramp_sb.active_type;
         case ($urandom_range(0, 5))
            0: it.target_value = 32'sh7FFF_FFFF;
            1: it.target_value = 32'sh8000_0000;
            2: it.target_value = $urandom_range(0, 2000) - 1000;
            3: it.target_value = $urandom_range(0, 1) ? 0 : -1;
            default: ;
         endcase
      end
      return it;
   endfunction

   task automatic send_item(req_item_type it);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = steady_phase ? 0 : $urandom_range(0, 12);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {it.target_value, it.ctrl_id};
      req_tuser  <= {it.setpoint_type, it.kind};
      do @(posedge clock); while (req_tready !== 1'b1);
      ramp_sb.note_item(it);
      items_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (ramp_sb.pending_cmds.size() != 0);
      // a tick without a send may still be dividing
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      ramp_sb.write_reg(index, data);
   endtask

   task automatic configure(logic [CSR_DATA_W-1:0] enable_raw,
                            logic [CSR_DATA_W-1:0] duration_raw,
                            logic [CSR_DATA_W-1:0] period_raw);
      write_reg(ssr_pkg::REG_ENABLE, enable_raw);
      write_reg(ssr_pkg::REG_DURATION, duration_raw);
      write_reg(ssr_pkg::REG_PERIOD, period_raw);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int unsigned           phase;
      int unsigned           phase_len;
      int unsigned           command_pct;
      logic [CSR_DATA_W-1:0] enable_raw;
      logic [CSR_DATA_W-1:0] duration_raw;
      logic [CSR_DATA_W-1:0] period_raw;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      configure(14'd1, 14'd4, 14'd1);
      // ticks before any command
      send_item(random_item(0));
      send_item(random_item(0));
      // full-range ramps in both directions
      send_item('{ssr_pkg::KIND_SETPOINT, 8'd255, TYPE_RPM, 32'sh7FFF_FFFF});
      repeat (3) send_item(random_item(0));
      send_item('{ssr_pkg::KIND_SETPOINT, 8'd0, TYPE_RPM, 32'sh8000_0000});
      repeat (5) send_item(random_item(0));
      // type changes apply at once
      send_item('{ssr_pkg::KIND_SETPOINT, 8'd17, TYPE_CURRENT, -32'sd5});
      send_item(random_item(0));
      send_item('{ssr_pkg::KIND_SETPOINT, 8'd42, TYPE_DUTY, 32'sd1000});
      send_item(random_item(0));
      send_item('{ssr_pkg::KIND_SETPOINT, 8'd128, TYPE_BRAKE, -32'sd1000});
      repeat (2) send_item(random_item(0));
      drain();

      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         case (phase)
            0: begin
               enable_raw   = 14'h3FFF;
               duration_raw = 14'h0000;
               period_raw   = 14'h3C00;
            end
            1: begin
               enable_raw   = 14'h0000;
               duration_raw = 14'h3FFF;
               period_raw   = 14'h3FFF;
            end
            2: begin
               enable_raw   = 14'h0001;
               duration_raw = 14'd10000;
               period_raw   = 14'd1000;
            end
            default: begin
               enable_raw    = CSR_DATA_W'($urandom);
               enable_raw[0] = ($urandom_range(0, 4) != 0);
               case ($urandom_range(0, 5))
                  0: duration_raw = CSR_DATA_W'($urandom);
                  1: duration_raw = 14'd500;
                  2: duration_raw = 14'd1;
                  default: duration_raw = CSR_DATA_W'($urandom_range(2, 40));
               endcase
               period_raw = CSR_DATA_W'($urandom);
               period_raw[PERIOD_W-1:0] = ($urandom_range(0, 9) == 0) ?
                                          PERIOD_W'($urandom_range(10, 40)) :
                                          PERIOD_W'($urandom_range(0, 4));
            end
         endcase
         configure(enable_raw, duration_raw, period_raw);
         steady_phase = ($urandom_range(0, 3) == 0);
         command_pct  = $urandom_range(5, 30);
         phase_len    = (phase < 3) ? 30 : $urandom_range(20, 80);
         repeat (phase_len) send_item(random_item(command_pct));
         drain();
         phase++;
      end

      if (ramp_sb.errors == 0 && ramp_sb.pending_cmds.size() == 0) begin
         $display("setpoint_soft_start_ramp_top verification clean");
      end else begin
         $display("setpoint_soft_start_ramp_top verification failed");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("setpoint_soft_start_ramp_top verification failed");
      $finish;
   end

endmodule

/* files.f */
rtl/core/ssr_pkg.sv
rtl/core/setpoint_soft_start_ramp_top.sv
rtl/core/ssr_checker.sv
tb/tb_setpoint_soft_start_ramp_top.sv
